// File: src/windowed_amplitude_histogram_macros.svh
// Assertion macros for the windowed amplitude histogram.
// Used by the top level only; needs no package.
`ifndef WINDOWED_AMPLITUDE_HISTOGRAM_MACROS_SVH
`define WINDOWED_AMPLITUDE_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define WAH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define WAH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WAH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WAH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/awh_pkg.sv
// Shared constants, types and helpers of the windowed amplitude histogram.
// No dependencies; used by awh_div and the top level.
package awh_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_BINS_DEF    = 64;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int unsigned BIN_COUNT_W   = 7;
    localparam int unsigned BIN_WIDTH_W   = 17;
    localparam int unsigned WIN_LEN_W     = 16;
    localparam int unsigned TOTAL_W       = 16;
    localparam int unsigned WIN_NUM_W     = 16;
    localparam int unsigned BIN_INDEX_W   = 6;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 17;
    // Wide enough to hold any bin count in use (up to 511).
    localparam int unsigned NB_W          = 9;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

    // Register reset values.
    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST     = 7'd16;
    localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST     = 17'd4096;
    localparam logic [WIN_LEN_W-1:0]   WINDOW_LENGTH_RST = 16'd1024;

    // Status of the divider.
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_nz;
    } div_stat_t;

    // Number of bins in use: zero means one, above the maximum saturates.
    function automatic logic [NB_W-1:0] bins_in_use(
        input logic [BIN_COUNT_W-1:0] bc,
        input logic [NB_W-1:0]        max_bins
    );
        logic [NB_W-1:0] bc_ext;
        bc_ext = {{(NB_W-BIN_COUNT_W){1'b0}}, bc};
        if (bc_ext == '0)
            return NB_W'(1);
        else if (bc_ext > max_bins)
            return max_bins;
        else
            return bc_ext;
    endfunction

endpackage

// File: src/awh_div.sv
// Restoring divider, one quotient bit per cycle, for the amplitude bin search.
// Depends on awh_pkg for widths and the status struct.
module awh_div #(
    parameter int unsigned SAMPLE_BITS = awh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [SAMPLE_BITS-1:0]             dividend,
    input  logic [awh_pkg::BIN_WIDTH_W-1:0]    divisor,
    output logic [SAMPLE_BITS-1:0]             quotient,
    output awh_pkg::div_stat_t                 stat
);

    localparam int unsigned BW    = awh_pkg::BIN_WIDTH_W;
    localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [BW-1:0]          rem_reg;
    logic [BW-1:0]          dvs_reg;
    logic [CNT_W-1:0]       step_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [BW:0]            shifted;
    logic [BW:0]            diff;
    logic                   ge;
    logic [BW-1:0]          rem_next;

    // One trial subtraction per cycle.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[BW-1:0] : shifted[BW-1:0];
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= CNT_W'(SAMPLE_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = (rem_reg != '0);

endmodule

// File: src/windowed_amplitude_histogram.sv
// Windowed amplitude histogram over awh_pkg and awh_div: one word per bin each window.
// A sample holds in_stall high while the one-bit-per-cycle divider runs, then through a counter
// read-modify-write when it updates a counter, and through the window check, so no new sample
// is accepted until the last one is through.
// At a window end each bin word takes a memory read and an output load, plus any result stall.
// Reset (rst_n, async, low) restores register defaults and marks all counters zero.
`include "windowed_amplitude_histogram_macros.svh"
module windowed_amplitude_histogram #(
    parameter int unsigned MAX_BINS    = awh_pkg::MAX_BINS_DEF,
    parameter int unsigned SAMPLE_BITS = awh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [awh_pkg::WIN_NUM_W-1:0]       window_number,
    output logic [awh_pkg::BIN_INDEX_W-1:0]     bin_index,
    output logic [awh_pkg::TOTAL_W-1:0]         bin_total,
    output logic                                last_bin,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [awh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [awh_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int unsigned NB_W  = awh_pkg::NB_W;
    localparam int unsigned CW    = SAMPLE_BITS + NB_W;
    localparam int unsigned TW    = awh_pkg::TOTAL_W;
    localparam int unsigned WLW   = awh_pkg::WIN_LEN_W;
    localparam int unsigned BIW   = awh_pkg::BIN_INDEX_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV     = 3'd1;
    localparam logic [2:0] ST_RD      = 3'd2;
    localparam logic [2:0] ST_UPD     = 3'd3;
    localparam logic [2:0] ST_CHK     = 3'd4;
    localparam logic [2:0] ST_EMIT_RD = 3'd5;
    localparam logic [2:0] ST_EMIT_LD = 3'd6;

    // Configuration registers.
    logic [awh_pkg::BIN_COUNT_W-1:0] bin_count_reg;
    logic [awh_pkg::BIN_WIDTH_W-1:0] bin_width_reg;
    logic [WLW-1:0]                  window_length_reg;

    // Control state.
    logic [2:0]              state_reg, state_next;
    logic [WLW-1:0]          samples_reg, samples_next;
    logic [awh_pkg::WIN_NUM_W-1:0] window_reg, window_next;
    logic [IDX_W-1:0]        bin_idx_reg, bin_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        emit_idx_reg, emit_idx_next;
    logic [MAX_BINS-1:0]     cnt_vld_reg, cnt_vld_next;
    logic                    out_valid_reg, out_valid_next;

    // Output payload.
    logic [awh_pkg::WIN_NUM_W-1:0] out_win_reg;
    logic [BIW-1:0]          out_idx_reg;
    logic [TW-1:0]           out_total_reg;
    logic                    out_last_reg;

    // Counter memory.
    logic [TW-1:0]           cnt_mem [MAX_BINS];
    logic [TW-1:0]           rd_data_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_we;
    logic [TW-1:0]           cur_total;
    logic [TW-1:0]           upd_total;

    // Divider interface.
    logic                    div_start;
    logic [SAMPLE_BITS-1:0]  offset;
    logic [SAMPLE_BITS-1:0]  quotient;
    awh_pkg::div_stat_t      div_stat;

    // Misc combinational.
    logic [NB_W-1:0]         nb;
    logic [CW-1:0]           q_ext;
    logic [CW-1:0]           nb_ext;
    logic [WLW:0]            count_plus;
    logic [WLW:0]            limit;
    logic [NB_W-1:0]         emit_plus;
    logic                    emit_last;
    logic                    out_load;
    logic [IDX_W+BIW-1:0]    emit_idx_wide;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    // Offset so the most negative sample maps to zero: flip the sign bit.
    assign offset    = sample ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign div_start = in_valid && !in_stall;

    awh_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (bin_width_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Bin selection and window bookkeeping values.
    always_comb
    begin
        nb         = awh_pkg::bins_in_use(bin_count_reg, NB_W'(MAX_BINS));
        q_ext      = {{NB_W{1'b0}}, quotient};
        nb_ext     = {{SAMPLE_BITS{1'b0}}, nb};
        count_plus = {1'b0, samples_reg} + (WLW+1)'(1);
        limit      = (window_length_reg == '0) ? {1'b1, {WLW{1'b0}}}
                                               : {1'b0, window_length_reg};
        emit_plus  = {{(NB_W-IDX_W){1'b0}}, emit_idx_reg} + NB_W'(1);
        emit_last  = (emit_plus == nb);
        out_load   = (state_reg == ST_EMIT_LD) && (!out_valid_reg || !out_stall);
        cur_total  = rd_vld_reg ? rd_data_reg : '0;
        upd_total  = (cur_total == {TW{1'b1}}) ? cur_total : cur_total + TW'(1);
        mem_we     = (state_reg == ST_UPD);
        rd_addr    = (state_reg == ST_RD) ? bin_idx_reg : emit_idx_reg;
        emit_idx_wide = {{BIW{1'b0}}, emit_idx_reg};
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        samples_next   = samples_reg;
        window_next    = window_reg;
        bin_idx_next   = bin_idx_reg;
        hit_next       = hit_reg;
        emit_idx_next  = emit_idx_reg;
        cnt_vld_next   = cnt_vld_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    hit_next     = (bin_width_reg != '0) && div_stat.rem_nz && (q_ext < nb_ext);
                    bin_idx_next = quotient[IDX_W-1:0];
                    state_next   = ((bin_width_reg != '0) && div_stat.rem_nz
                                    && (q_ext < nb_ext)) ? ST_RD : ST_CHK;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cnt_vld_next[bin_idx_reg] = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (count_plus < limit)
                begin
                    samples_next = count_plus[WLW-1:0];
                    state_next   = ST_IDLE;
                end
                else
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (emit_last)
                    begin
                        cnt_vld_next = '0;
                        samples_next = '0;
                        window_next  = window_reg + 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_plus[IDX_W-1:0];
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            samples_reg       <= '0;
            window_reg        <= '0;
            bin_idx_reg       <= '0;
            hit_reg           <= 1'b0;
            emit_idx_reg      <= '0;
            cnt_vld_reg       <= '0;
            out_valid_reg     <= 1'b0;
            bin_count_reg     <= awh_pkg::BIN_COUNT_RST;
            bin_width_reg     <= awh_pkg::BIN_WIDTH_RST;
            window_length_reg <= awh_pkg::WINDOW_LENGTH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            samples_reg   <= samples_next;
            window_reg    <= window_next;
            bin_idx_reg   <= bin_idx_next;
            hit_reg       <= hit_next;
            emit_idx_reg  <= emit_idx_next;
            cnt_vld_reg   <= cnt_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    awh_pkg::REG_BIN_COUNT:
                        bin_count_reg <= cfg_data[awh_pkg::BIN_COUNT_W-1:0];
                    awh_pkg::REG_BIN_WIDTH:
                        bin_width_reg <= cfg_data[awh_pkg::BIN_WIDTH_W-1:0];
                    awh_pkg::REG_WINDOW_LENGTH:
                        window_length_reg <= cfg_data[WLW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[bin_idx_reg] <= upd_total;
        rd_data_reg <= cnt_mem[rd_addr];
        rd_vld_reg  <= cnt_vld_reg[rd_addr];
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_win_reg   <= window_reg;
            out_idx_reg   <= emit_idx_wide[BIW-1:0];
            out_total_reg <= cur_total;
            out_last_reg  <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_number = out_win_reg;
    assign bin_index     = out_idx_reg;
    assign bin_total     = out_total_reg;
    assign last_bin      = out_last_reg;

    // Checks on the sequencer.
    `WAH_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV)
    `WAH_ASSERT_IMP(a_upd_bin_in_use, clk, rst_n, state_reg == ST_RD, hit_reg && ({{(NB_W-IDX_W){1'b0}}, bin_idx_reg} < nb))
    `WAH_ASSERT_NXT(a_window_end_clears, clk, rst_n, out_load && emit_last, (cnt_vld_reg == '0) && (samples_reg == '0) && (state_reg == ST_IDLE))

endmodule
